// ===== hdl/scti_pkg.sv =====
package scti_pkg;

   // Field widths of the two channels.
   localparam int ANGLE_W  = 32;
   localparam int VALUE_W  = 17;
   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 16;

   // Quarter-wave table geometry.
   localparam int TABLE_POINTS = 41;
   localparam int CELLS        = TABLE_POINTS - 1;
   localparam int IDX_W        = $clog2(TABLE_POINTS);
   localparam int POS_W        = IDX_W + FRAC_W;

   // Angle constants in Q32.32.
   localparam logic [63:0] PI_Q32      = 64'd13493037705;
   localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
   localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;

   localparam int TP_W = $clog2(TWO_PI_Q32 + 64'd1);
   localparam int PI_W = $clog2(PI_Q32 + 64'd1);
   localparam int M_W  = $clog2(HALF_PI_Q32 + 64'd1);
   localparam int R0_W = TP_W + 1;
   localparam int REM_W = PI_W + 1;

   localparam logic [TP_W-1:0] TWO_PI_V  = TP_W'(TWO_PI_Q32);
   localparam logic [PI_W-1:0] PI_V      = PI_W'(PI_Q32);
   localparam logic [M_W-1:0]  HALF_PI_V = M_W'(HALF_PI_Q32);

   // Angle widened to Q32.32, with room for the cosine offset.
   localparam int ANGLE_SHIFT = 16;
   localparam int A_W         = ANGLE_W + ANGLE_SHIFT + 1;

   // Turn count estimate: top bits of the angle times a reciprocal of 2*pi.
   // The reciprocal is kept rounded down and rounded up.
   localparam int TRUNC_SHIFT = 20;
   localparam int RECIP_SHIFT = 32;
   localparam int T_W         = A_W - TRUNC_SHIFT;
   localparam int QE_W        = 16;
   localparam logic [63:0] RED_RECIP_FULL =
      (64'd1 << (RECIP_SHIFT + TRUNC_SHIFT)) / TWO_PI_Q32;
   localparam int RR_W = $clog2(RED_RECIP_FULL + 64'd2);
   localparam logic [RR_W-1:0] RED_RECIP    = RR_W'(RED_RECIP_FULL);
   localparam logic [RR_W-1:0] RED_RECIP_UP = RR_W'(RED_RECIP_FULL + 64'd1);

   // Cell position estimate: pos = m * POS_SCALE / pi.
   localparam logic [63:0] POS_SCALE = 64'(2 * CELLS) << FRAC_W;
   localparam int PS_W    = $clog2(POS_SCALE + 64'd1);
   localparam int M_SHIFT = 8;
   localparam logic [63:0] POS_RECIP_FULL =
      64'((128'(POS_SCALE) << (RECIP_SHIFT + M_SHIFT)) / 128'(PI_Q32));
   localparam int PR_W = $clog2(POS_RECIP_FULL + 64'd1);
   localparam logic [PR_W-1:0] POS_RECIP   = PR_W'(POS_RECIP_FULL);
   localparam logic [PS_W-1:0] POS_SCALE_V = PS_W'(POS_SCALE);

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd65535;
   localparam logic [2*SAMPLE_W:0] ROUND_HALF = (2*SAMPLE_W+1)'(1) << (FRAC_W - 1);

   // Pipeline depth from input register to output register.
   localparam int STAGES = 13;

   // round(65535 * sin(i * pi / 80)) for i = 0 .. 40.
   localparam logic [SAMPLE_W-1:0] SINE_TABLE [TABLE_POINTS] = '{
      16'd0,     16'd2573,  16'd5142,  16'd7703,  16'd10252, 16'd12785,
      16'd15299, 16'd17789, 16'd20251, 16'd22683, 16'd25079, 16'd27437,
      16'd29752, 16'd32022, 16'd34242, 16'd36409, 16'd38521, 16'd40572,
      16'd42562, 16'd44485, 16'd46340, 16'd48124, 16'd49833, 16'd51466,
      16'd53019, 16'd54490, 16'd55878, 16'd57179, 16'd58392, 16'd59515,
      16'd60546, 16'd61484, 16'd62327, 16'd63075, 16'd63724, 16'd64276,
      16'd64728, 16'd65081, 16'd65333, 16'd65484, 16'd65535
   };

   // Table read that returns zero for codes past the last entry.
   function automatic logic [SAMPLE_W-1:0] sine_entry(input logic [IDX_W-1:0] idx);
      logic [SAMPLE_W-1:0] entry;
      entry = '0;
      if (idx < IDX_W'(TABLE_POINTS)) begin
         entry = SINE_TABLE[idx];
      end
      return entry;
   endfunction

endpackage

// ===== hdl/sine_cosine_table_interp_unit.sv =====
// Channel   Direction  Ports                                    Word
// req       in         req_valid, req_ready, req_operation,     operation (0 sine, 1 cosine),
//                      req_angle                                angle in radians, Q16.16
// rsp       out        rsp_valid, rsp_ready, rsp_value          sine or cosine, signed, 65535 = 1.0
//
// Every word passes 13 register stages; the first is loaded at the edge that accepts it, and the
// last drives rsp_valid. A new word may enter in every cycle while req_ready is high; the depth is
// set by the two reciprocal divisions, each a multiply, a multiply back and a correction, plus
// the reduction, the fold, the table step and the interpolation multiply.
// Synchronous reset clears the valid bit of every stage; data registers are not reset.
// Each stage holds its word while the stage after it is full and stalled, so a stall of rsp
// fills the empty stages first and only then drops req_ready.
module sine_cosine_table_interp_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [scti_pkg::ANGLE_W-1:0] req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [scti_pkg::VALUE_W-1:0] rsp_value
);
   import scti_pkg::*;

   // A stage may load when the output is being taken or when it or any stage after it is
   // empty. That way a bubble anywhere downstream lets the upstream words move up.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         load[k] = rsp_ready | ~(&(valid_ff | ~({STAGES{1'b1}} << k)));
      end
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Stage 0: widen the angle to Q32.32 and add pi/2 for cosine.
   logic signed [A_W-1:0] s0_angle_ff, s0_angle_in;

   always_comb begin
      s0_angle_in = (A_W'(req_angle) <<< ANGLE_SHIFT)
                  + (req_operation ? $signed(A_W'(HALF_PI_V)) : $signed(A_W'(0)));
   end

   // Stage 1: estimate the turn count as floor(angle / 2*pi) from the top bits of the angle.
   // A negative angle is scaled by the reciprocal rounded up and a positive one by the
   // reciprocal rounded down, so the estimate never overshoots and falls short by at most
   // one turn.
   logic signed [QE_W-1:0] s1_quot_ff, s1_quot_in;
   logic [R0_W-1:0]        s1_low_ff, s1_low_in;

   always_comb begin
      logic signed [T_W-1:0]      trunc;
      logic [RR_W-1:0]            recip;
      logic signed [T_W+RR_W:0]   quot_full;
      trunc      = s0_angle_ff[A_W-1:TRUNC_SHIFT];
      recip      = trunc[T_W-1] ? RED_RECIP_UP : RED_RECIP;
      quot_full  = trunc * $signed({1'b0, recip});
      s1_quot_in = quot_full[RECIP_SHIFT +: QE_W];
      s1_low_in  = s0_angle_ff[R0_W-1:0];
   end

   // Stage 2: multiply the turn count back by 2*pi. Only the low bits matter, since the
   // remainder is known to lie below twice 2*pi.
   logic [R0_W-1:0] s2_qprod_ff, s2_qprod_in;
   logic [R0_W-1:0] s2_low_ff, s2_low_in;

   always_comb begin
      logic signed [QE_W+TP_W:0] qprod_full;
      qprod_full  = s1_quot_ff * $signed({1'b0, TWO_PI_V});
      s2_qprod_in = qprod_full[R0_W-1:0];
      s2_low_in   = s1_low_ff;
   end

   // Stage 3: first remainder, somewhere in [0, 2 * 2*pi).
   logic [R0_W-1:0] s3_resid_ff, s3_resid_in;

   always_comb begin
      s3_resid_in = s2_low_ff - s2_qprod_ff;
   end

   // Stage 4: correct the short estimate, giving the remainder in [0, 2*pi).
   logic [TP_W-1:0] s4_resid_ff, s4_resid_in;

   always_comb begin
      logic [R0_W-1:0] diff;
      diff = s3_resid_ff - R0_W'(TWO_PI_V);
      if (s3_resid_ff >= R0_W'(TWO_PI_V)) begin
         s4_resid_in = diff[TP_W-1:0];
      end else begin
         s4_resid_in = s3_resid_ff[TP_W-1:0];
      end
   end

   // Stage 5: a remainder above pi stands for a negative angle; keep its magnitude.
   logic            s5_neg_ff, s5_neg_in;
   logic [PI_W-1:0] s5_mag_ff, s5_mag_in;

   always_comb begin
      logic [TP_W-1:0] mirror;
      mirror    = TWO_PI_V - s4_resid_ff;
      s5_neg_in = s4_resid_ff > TP_W'(PI_V);
      s5_mag_in = s5_neg_in ? mirror[PI_W-1:0] : s4_resid_ff[PI_W-1:0];
   end

   // Stage 6: fold an obtuse magnitude into the first quadrant.
   logic           s6_neg_ff, s6_neg_in;
   logic [M_W-1:0] s6_fold_ff, s6_fold_in;

   always_comb begin
      logic [PI_W-1:0] rest;
      rest       = PI_V - s5_mag_ff;
      s6_neg_in  = s5_neg_ff;
      s6_fold_in = (s5_mag_ff > rest) ? rest[M_W-1:0] : s5_mag_ff[M_W-1:0];
   end

   // Stage 7: estimate the cell position m * 80 * 2^16 / pi from the top bits of m.
   logic             s7_neg_ff, s7_neg_in;
   logic [M_W-1:0]   s7_fold_ff, s7_fold_in;
   logic [POS_W-1:0] s7_pos_ff, s7_pos_in;

   always_comb begin
      logic [M_W-M_SHIFT+PR_W-1:0] est_full;
      est_full   = s6_fold_ff[M_W-1:M_SHIFT] * POS_RECIP;
      s7_pos_in  = est_full[RECIP_SHIFT +: POS_W];
      s7_neg_in  = s6_neg_ff;
      s7_fold_in = s6_fold_ff;
   end

   // Stage 8: both sides of the position check, kept to the bits the remainder needs.
   logic             s8_neg_ff, s8_neg_in;
   logic [REM_W-1:0] s8_scaled_ff, s8_scaled_in;
   logic [REM_W-1:0] s8_back_ff, s8_back_in;
   logic [POS_W-1:0] s8_pos_ff, s8_pos_in;

   always_comb begin
      logic [M_W+PS_W-1:0]   scaled_full;
      logic [POS_W+PI_W-1:0] back_full;
      scaled_full  = s7_fold_ff * POS_SCALE_V;
      back_full    = s7_pos_ff * PI_V;
      s8_scaled_in = scaled_full[REM_W-1:0];
      s8_back_in   = back_full[REM_W-1:0];
      s8_neg_in    = s7_neg_ff;
      s8_pos_in    = s7_pos_ff;
   end

   // Stage 9: a remainder of pi or more means the estimate was one short.
   logic             s9_neg_ff, s9_neg_in;
   logic [POS_W-1:0] s9_pos_ff, s9_pos_in;

   always_comb begin
      logic [REM_W-1:0] rem;
      rem       = s8_scaled_ff - s8_back_ff;
      s9_pos_in = (rem >= REM_W'(PI_V)) ? POS_W'(s8_pos_ff + 1'b1) : s8_pos_ff;
      s9_neg_in = s8_neg_ff;
   end

   // Stage 10: read both ends of the cell. At or past the last entry the result is full scale.
   logic                s10_neg_ff, s10_neg_in;
   logic                s10_sat_ff, s10_sat_in;
   logic [SAMPLE_W-1:0] s10_lo_ff, s10_lo_in;
   logic [SAMPLE_W-1:0] s10_diff_ff, s10_diff_in;
   logic [FRAC_W-1:0]   s10_frac_ff, s10_frac_in;

   always_comb begin
      logic [IDX_W-1:0]    idx;
      logic [SAMPLE_W-1:0] hi;
      idx         = s9_pos_ff[POS_W-1:FRAC_W];
      s10_frac_in = s9_pos_ff[FRAC_W-1:0];
      s10_sat_in  = idx >= IDX_W'(CELLS);
      s10_lo_in   = sine_entry(idx);
      hi          = sine_entry(IDX_W'(idx + 1'b1));
      s10_diff_in = (hi >= s10_lo_in) ? hi - s10_lo_in : '0;
      s10_neg_in  = s9_neg_ff;
   end

   // Stage 11: slope times fraction.
   logic                  s11_neg_ff, s11_neg_in;
   logic                  s11_sat_ff, s11_sat_in;
   logic [SAMPLE_W-1:0]   s11_lo_ff, s11_lo_in;
   logic [2*SAMPLE_W-1:0] s11_prod_ff, s11_prod_in;

   always_comb begin
      s11_prod_in = s10_diff_ff * s10_frac_ff;
      s11_neg_in  = s10_neg_ff;
      s11_sat_in  = s10_sat_ff;
      s11_lo_in   = s10_lo_ff;
   end

   // Stage 12: round half up, add to the lower point and apply the sign. This is the
   // output register.
   logic signed [VALUE_W-1:0] s12_value_ff, s12_value_in;

   always_comb begin
      logic [2*SAMPLE_W:0] rnd;
      logic [VALUE_W-1:0]  mag;
      rnd = {1'b0, s11_prod_ff} + ROUND_HALF;
      if (s11_sat_ff) begin
         mag = VALUE_W'(FULL_SCALE);
      end else begin
         mag = VALUE_W'(s11_lo_ff) + VALUE_W'(rnd >> FRAC_W);
      end
      s12_value_in = s11_neg_ff ? $signed(-mag) : $signed(mag);
   end

   assign rsp_value = s12_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end

      if (load[0]) begin
         s0_angle_ff <= s0_angle_in;
      end
      if (load[1]) begin
         s1_quot_ff <= s1_quot_in;
         s1_low_ff  <= s1_low_in;
      end
      if (load[2]) begin
         s2_qprod_ff <= s2_qprod_in;
         s2_low_ff   <= s2_low_in;
      end
      if (load[3]) begin
         s3_resid_ff <= s3_resid_in;
      end
      if (load[4]) begin
         s4_resid_ff <= s4_resid_in;
      end
      if (load[5]) begin
         s5_neg_ff <= s5_neg_in;
         s5_mag_ff <= s5_mag_in;
      end
      if (load[6]) begin
         s6_neg_ff  <= s6_neg_in;
         s6_fold_ff <= s6_fold_in;
      end
      if (load[7]) begin
         s7_neg_ff  <= s7_neg_in;
         s7_fold_ff <= s7_fold_in;
         s7_pos_ff  <= s7_pos_in;
      end
      if (load[8]) begin
         s8_neg_ff    <= s8_neg_in;
         s8_scaled_ff <= s8_scaled_in;
         s8_back_ff   <= s8_back_in;
         s8_pos_ff    <= s8_pos_in;
      end
      if (load[9]) begin
         s9_neg_ff <= s9_neg_in;
         s9_pos_ff <= s9_pos_in;
      end
      if (load[10]) begin
         s10_neg_ff  <= s10_neg_in;
         s10_sat_ff  <= s10_sat_in;
         s10_lo_ff   <= s10_lo_in;
         s10_diff_ff <= s10_diff_in;
         s10_frac_ff <= s10_frac_in;
      end
      if (load[11]) begin
         s11_neg_ff  <= s11_neg_in;
         s11_sat_ff  <= s11_sat_in;
         s11_lo_ff   <= s11_lo_in;
         s11_prod_ff <= s11_prod_in;
      end
      if (load[12]) begin
         s12_value_ff <= s12_value_in;
      end
   end

endmodule
